### src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge of clk, idle while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication form of the same check
`define ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### src/rbfp_pkg.sv
package rbfp_pkg;

	localparam int WORD_W  = 64;
	localparam int COUNT_W = 48;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_PRIME = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED  = 1'b1;

	localparam logic [WORD_W-1:0]  RESET_PRIME = 64'h8000_0000_0000_001d;
	localparam logic [WORD_W-1:0]  RESET_SEED  = 64'h0;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

	// shift-subtract steps for a short pass (high half already reduced) and a full pass
	localparam int STEP_W = 8;
	localparam logic [STEP_W-1:0] STEPS_HALF = 8'd64;
	localparam logic [STEP_W-1:0] STEPS_FULL = 8'd128;

	typedef struct packed {
		logic [WORD_W-1:0] block_value;
		logic              first_block;
	} blk_t;

	typedef struct packed {
		logic [WORD_W-1:0]  stored_word;
		logic [WORD_W-1:0]  new_fingerprint;
		logic               above_prime;
		logic               collision;
		logic [COUNT_W-1:0] high_block_count;
	} res_t;

endpackage

### src/rolling_block_fingerprint_mod_prime.sv
// channel | direction | handshake            | payload
// blk     | in        | blk_valid, blk_stall | blk_t: block_value, first_block
// res     | out       | res_valid, res_stall | res_t: fingerprint words, flags, count
// cfg     | in        | cfg_we               | cfg_index, cfg_data (no read-back)
//
// result after a short pass when the flag-stripped old fingerprint is
// below the prime (or the prime is zero), else after a full pass, one dividend bit per cycle on the
// shared 65-bit compare-subtract unit; the next block is taken once the result is loaded
// reset clears state, fingerprint, count and loads the default prime and seed
// blk_stall is high from transfer until the result sits in the output register;
// a stalled result holds the finished item, the next block starts meanwhile
`include "assert_macros.svh"

module rolling_block_fingerprint_mod_prime
	import rbfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// block input channel
	input  logic                 blk_valid,
	output logic                 blk_stall,
	input  blk_t                 blk,
	// result output channel
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t               state_q;
	logic [STEP_W-1:0]    step_cnt_q;
	logic [WORD_W-1:0]    prime_q;
	logic [WORD_W-1:0]    seed_q;
	logic [WORD_W-1:0]    fp_q;
	logic [COUNT_W-1:0]   high_cnt_q;
	logic [WORD_W-1:0]    rem_q;
	logic [2*WORD_W-1:0]  div_q;
	logic [WORD_W-1:0]    old_q;
	logic                 above_q;
	logic                 res_valid_q;
	res_t                 res_q;

	// accept-side decode
	logic                 blk_xfer;
	logic [WORD_W-1:0]    old_fp;
	logic [WORD_W-1:0]    hi_part;
	logic                 short_pass;
	logic                 above;
	logic [COUNT_W-1:0]   cnt_base;
	logic [COUNT_W-1:0]   cnt_next;

	// shared compare-subtract unit
	logic                 sub_carry;
	logic [WORD_W-1:0]    sub_shifted;
	logic [WORD_W:0]      sub_diff;
	logic                 sub_ge;
	logic [WORD_W-1:0]    sub_rem;

	// finish-side
	logic                 res_xfer;
	logic                 res_load;
	logic [WORD_W-1:0]    fp_next;

	assign blk_stall = (state_q != ST_IDLE);
	assign blk_xfer  = blk_valid && !blk_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign res_xfer  = res_valid_q && !res_stall;

	// first block restarts the chain from the seed and clears the count
	assign old_fp   = blk.first_block ? seed_q : fp_q;
	assign hi_part  = {1'b0, old_fp[WORD_W-2:0]};
	// when the high half is already below the prime its 64 steps leave it unchanged
	assign short_pass = (hi_part < prime_q) || (prime_q == '0);
	assign above    = (blk.block_value >= prime_q);
	assign cnt_base = blk.first_block ? '0 : high_cnt_q;
	assign cnt_next = (above && (cnt_base != COUNT_MAX)) ? cnt_base + 1'b1 : cnt_base;

	// one restoring step: shift in the next dividend bit, subtract the prime when the 65-bit value is not below it
	assign sub_carry   = rem_q[WORD_W-1];
	assign sub_shifted = {rem_q[WORD_W-2:0], div_q[2*WORD_W-1]};
	assign sub_diff    = {sub_carry, sub_shifted} - {1'b0, prime_q};
	assign sub_ge      = !sub_diff[WORD_W];
	assign sub_rem     = sub_ge ? sub_diff[WORD_W-1:0] : sub_shifted;

	// output slot is free when empty or draining this cycle
	assign res_load = (state_q == ST_HOLD) && (!res_valid_q || !res_stall);
	assign fp_next  = {rem_q[WORD_W-1] | above_q, rem_q[WORD_W-2:0]};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= RESET_PRIME;
			seed_q  <= RESET_SEED;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRIME: prime_q <= cfg_data;
				REG_SEED:  seed_q  <= cfg_data;
				default:   ;
			endcase
		end
	end

	// sequencer, chain state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_cnt_q  <= '0;
			fp_q        <= '0;
			high_cnt_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// a drained slot that is refilled this cycle is set below instead
			if (res_xfer && !res_load) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (blk_xfer) begin
						old_q      <= old_fp;
						above_q    <= above;
						high_cnt_q <= cnt_next;
						if (short_pass) begin
							rem_q      <= hi_part;
							div_q      <= {blk.block_value, {WORD_W{1'b0}}};
							step_cnt_q <= STEPS_HALF;
						end else begin
							rem_q      <= '0;
							div_q      <= {hi_part, blk.block_value};
							step_cnt_q <= STEPS_FULL;
						end
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (step_cnt_q != '0) begin
						rem_q      <= sub_rem;
						div_q      <= {div_q[2*WORD_W-2:0], 1'b0};
						step_cnt_q <= step_cnt_q - 1'b1;
					end else begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (res_load) begin
						res_q.stored_word      <= old_q;
						res_q.new_fingerprint  <= fp_next;
						res_q.above_prime      <= above_q;
						res_q.collision        <= rem_q[WORD_W-1];
						res_q.high_block_count <= high_cnt_q;
						res_valid_q            <= 1'b1;
						fp_q                   <= fp_next;
						state_q                <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// step counter only runs inside the divide
	`ASSERT_IMPL(a_idle_cnt_zero, state_q != ST_RUN, step_cnt_q == '0,
		"step counter active outside run")
	// an accepted block always starts the divider
	`ASSERT_NEXT(a_xfer_starts_run, blk_xfer, state_q == ST_RUN,
		"accepted block did not start the divider")
	// a drained result is not replaced unless the finish stage loads a new one
	`ASSERT_NEXT(a_drain_clears, res_xfer && (state_q != ST_HOLD), !res_valid,
		"result valid held after transfer without a new result")

endmodule
